// ===== rtl/atcb_pkg.sv =====
// Shared types, constants and register codes for the auto-trim bounds block.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package atcb_pkg;

    localparam int MAX_SIDE   = 16384;
    localparam int COORD_W    = 14;
    localparam int SIDE_W     = 15;
    localparam int CHAN_W     = 16;
    localparam int TOL_W      = 8;
    localparam int SIDES_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 64;
    localparam int SIDE_CAP   = (MAX_SIDE < 16384) ? MAX_SIDE : 16384;

    localparam logic [COORD_W-1:0] COORD_ONES = {COORD_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIM_MODE = 3'd0,
        CFG_TOLERANCE = 3'd1,
        CFG_REFERENCE = 3'd2,
        CFG_SIDES     = 3'd3,
        CFG_WIDTH     = 3'd4,
        CFG_HEIGHT    = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_TRIM     = 2'd0,
        ST_NO_SIDES = 2'd1,
        ST_ALL_BG   = 2'd2,
        ST_TIGHT    = 2'd3
    } t_status;

    // Decoded configuration, shared by front and back.
    typedef struct packed {
        logic                   trim_mode;
        logic [CHAN_W-1:0]      tol_scaled;   // tolerance * 257
        logic [CHAN_W-1:0]      ref_red;
        logic [CHAN_W-1:0]      ref_green;
        logic [CHAN_W-1:0]      ref_blue;
        logic [CHAN_W-1:0]      ref_alpha;
        logic [SIDES_W-1:0]     sides;
        logic [COORD_W-1:0]     last_col;     // effective width - 1
        logic [COORD_W-1:0]     last_row;     // effective height - 1
    } t_cfg;

    // Classified pixel word passed from front to back.
    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } t_result;

endpackage

// ===== rtl/atcb_cfg.sv =====
// Configuration register file: decodes writes and precomputes canvas limits.
// Depends on atcb_pkg.
`timescale 1ns / 1ps

module atcb_cfg
    import atcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Zero counts as one, oversize clamps to the cap; store side - 1.
    function automatic logic [COORD_W-1:0] last_index(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] m;
        m = v - SIDE_W'(1);
        if (v == '0)
            return '0;
        else if (v > SIDE_W'(SIDE_CAP))
            return COORD_W'(SIDE_CAP - 1);
        else
            return m[COORD_W-1:0];
    endfunction

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_TRIM_MODE: n_cfg.trim_mode = i_cfg_data[0];
                CFG_TOLERANCE: n_cfg.tol_scaled = {i_cfg_data[TOL_W-1:0],
                                                   i_cfg_data[TOL_W-1:0]};
                CFG_REFERENCE: begin
                    n_cfg.ref_red   = i_cfg_data[63:48];
                    n_cfg.ref_green = i_cfg_data[47:32];
                    n_cfg.ref_blue  = i_cfg_data[31:16];
                    n_cfg.ref_alpha = i_cfg_data[15:0];
                end
                CFG_SIDES:  n_cfg.sides    = i_cfg_data[SIDES_W-1:0];
                CFG_WIDTH:  n_cfg.last_col = last_index(i_cfg_data[SIDE_W-1:0]);
                CFG_HEIGHT: n_cfg.last_row = last_index(i_cfg_data[SIDE_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trim_mode  <= 1'b0;
            r_cfg.tol_scaled <= '0;
            r_cfg.ref_red    <= '0;
            r_cfg.ref_green  <= '0;
            r_cfg.ref_blue   <= '0;
            r_cfg.ref_alpha  <= '0;
            r_cfg.sides      <= '1;
            r_cfg.last_col   <= COORD_W'(SIDE_CAP - 1);
            r_cfg.last_row   <= COORD_W'(SIDE_CAP - 1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ===== rtl/atcb_front.sv =====
// Front end: unpacks a pixel word and classifies it as content inside the canvas.
// Depends on atcb_pkg.
`timescale 1ns / 1ps

module atcb_front
    import atcb_pkg::*;
(
    input  t_cfg                 i_cfg,
    input  logic [IN_DATA_W-1:0] i_tdata,  // red, green, blue, alpha, x, y
    input  logic                 i_tlast,  // frame_last
    output t_item                o_item
);

    logic [CHAN_W-1:0]  w_red, w_green, w_blue, w_alpha;
    logic [COORD_W-1:0] w_x, w_y;
    logic               w_match, w_content, w_inside;

    function automatic logic near(input logic [CHAN_W-1:0] a,
                                  input logic [CHAN_W-1:0] b,
                                  input logic [CHAN_W-1:0] tol);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

    assign w_red   = i_tdata[15:0];
    assign w_green = i_tdata[31:16];
    assign w_blue  = i_tdata[47:32];
    assign w_alpha = i_tdata[63:48];
    assign w_x     = i_tdata[77:64];
    assign w_y     = i_tdata[91:78];

    // Two fully transparent pixels match regardless of color.
    assign w_match = ((w_alpha == '0) && (i_cfg.ref_alpha == '0)) ||
                     (near(w_red,   i_cfg.ref_red,   i_cfg.tol_scaled) &&
                      near(w_green, i_cfg.ref_green, i_cfg.tol_scaled) &&
                      near(w_blue,  i_cfg.ref_blue,  i_cfg.tol_scaled) &&
                      near(w_alpha, i_cfg.ref_alpha, i_cfg.tol_scaled));

    assign w_content = i_cfg.trim_mode ? !w_match : (w_alpha != '0);
    assign w_inside  = (w_x <= i_cfg.last_col) && (w_y <= i_cfg.last_row);

    assign o_item.hit  = w_content && w_inside;
    assign o_item.x    = w_x;
    assign o_item.y    = w_y;
    assign o_item.last = i_tlast;

endmodule

// ===== rtl/atcb_fifo.sv =====
// Four-entry queue of classified pixel words between front and back.
// Depends on atcb_pkg.
`timescale 1ns / 1ps

module atcb_fifo
    import atcb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count,  n_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/atcb_back.sv =====
// Back end: accumulates content bounds and builds the trim result on frame end.
// Depends on atcb_pkg.
`timescale 1ns / 1ps

module atcb_back
    import atcb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    logic [COORD_W-1:0] r_min_col, n_min_col, r_max_col, n_max_col;
    logic [COORD_W-1:0] r_min_row, n_min_row, r_max_row, n_max_row;
    logic               r_seen, n_seen;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic [COORD_W-1:0] w_min_col, w_max_col, w_min_row, w_max_row;
    logic               w_seen, w_take_l, w_take_r, w_take_t, w_take_b;
    t_result            w_res;

    // Non-final words never need the output slot.
    assign o_pop = i_valid && (!i_item.last || !r_out_valid || i_res_ready);

    // Bounds including the word at the head of the queue.
    always_comb begin
        w_min_col = (i_item.hit && i_item.x < r_min_col) ? i_item.x : r_min_col;
        w_max_col = (i_item.hit && i_item.x > r_max_col) ? i_item.x : r_max_col;
        w_min_row = (i_item.hit && i_item.y < r_min_row) ? i_item.y : r_min_row;
        w_max_row = (i_item.hit && i_item.y > r_max_row) ? i_item.y : r_max_row;
        w_seen    = r_seen || i_item.hit;
    end

    always_comb begin
        w_take_l = !i_cfg.trim_mode || i_cfg.sides[0];
        w_take_r = !i_cfg.trim_mode || i_cfg.sides[1];
        w_take_t = !i_cfg.trim_mode || i_cfg.sides[2];
        w_take_b = !i_cfg.trim_mode || i_cfg.sides[3];
        w_res.left   = '0;
        w_res.top    = '0;
        w_res.right  = i_cfg.last_col;
        w_res.bottom = i_cfg.last_row;
        if (i_cfg.trim_mode && (i_cfg.sides == '0)) begin
            w_res.status = ST_NO_SIDES;
        end else if (!w_seen) begin
            w_res.status = ST_ALL_BG;
        end else begin
            if (w_take_l) w_res.left   = w_min_col;
            if (w_take_r) w_res.right  = w_max_col;
            if (w_take_t) w_res.top    = w_min_row;
            if (w_take_b) w_res.bottom = w_max_row;
            w_res.status = ((w_res.left == '0) && (w_res.top == '0) &&
                            (w_res.right == i_cfg.last_col) &&
                            (w_res.bottom == i_cfg.last_row)) ? ST_TIGHT : ST_TRIM;
        end
    end

    always_comb begin
        n_min_col   = r_min_col;
        n_max_col   = r_max_col;
        n_min_row   = r_min_row;
        n_max_row   = r_max_row;
        n_seen      = r_seen;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        if (o_pop) begin
            if (i_item.last) begin
                n_min_col   = COORD_ONES;
                n_max_col   = '0;
                n_min_row   = COORD_ONES;
                n_max_row   = '0;
                n_seen      = 1'b0;
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_min_col = w_min_col;
                n_max_col = w_max_col;
                n_min_row = w_min_row;
                n_max_row = w_max_row;
                n_seen    = w_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col   <= COORD_ONES;
            r_max_col   <= '0;
            r_min_row   <= COORD_ONES;
            r_max_row   <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_min_col   <= n_min_col;
            r_max_col   <= n_max_col;
            r_min_row   <= n_min_row;
            r_max_row   <= n_max_row;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_bounds_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_min_col == COORD_ONES) && (r_max_col == '0) &&
                    (r_min_row == COORD_ONES) && (r_max_row == '0))
        else $error("bounds not at reset value with no content seen");

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> !r_seen && r_out_valid)
        else $error("frame end did not clear bounds or load result");

    a_rect_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.left <= r_out.right) && (r_out.top <= r_out.bottom))
        else $error("result rectangle is empty");

    a_rect_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.right <= i_cfg.last_col) &&
                        (r_out.bottom <= i_cfg.last_row))
        else $error("result rectangle exceeds canvas");

endmodule

// ===== rtl/auto_trim_content_bounds.sv =====
// Top level of the auto-trim content bounds block.
// Depends on atcb_pkg, atcb_cfg, atcb_front, atcb_fifo, atcb_back.
//
// Usage:
//   Pixels enter on the s_axis stream, one word per clock while tready is high: tdata carries
//   red, green, blue, alpha (16 bits each), column and row (14 bits each);
//   tlast marks the final pixel of a frame. Each frame end yields one word on
//   m_axis: status (2 bits) then left, top, right, bottom (14 bits each).
//   Registers are written over the cfg channel (index, 64-bit data), which is
//   always ready; write only while no frame is in flight.
// Timing:
//   One pixel per clock while s_axis tready is high. The frame's last pixel is
//   classified and written into the four-entry queue; the bounds stage then
//   loads the result word into the output register that drives m_axis.
// Stalls:
//   While a result waits on m_axis, pixels of the next frame keep flowing into
//   the bounds stage; only a second frame end waits, and s_axis drops tready
//   once the queue fills.
// Reset:
//   Synchronous, active low. Clears the queue, the bounds and the output
//   valid flag; registers return to mode 0, tolerance 0, reference 0, all four
//   sides, and a 16384 by 16384 canvas.
`timescale 1ns / 1ps

module auto_trim_content_bounds
    import atcb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // red[15:0], green[31:16], blue[47:32], alpha[63:48], x[77:64], y[91:78]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status[1:0], left[15:2], top[29:16], right[43:30], bottom[57:44]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_item   w_front_item, w_queue_item;
    t_result w_res;
    logic    w_full, w_push, w_pop, w_queue_valid;

    atcb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    atcb_front u_front (
        .i_cfg   (w_cfg),
        .i_tdata (i_s_axis_tdata),
        .i_tlast (i_s_axis_tlast),
        .o_item  (w_front_item)
    );

    assign o_s_axis_tready = !w_full;
    assign w_push          = i_s_axis_tvalid && !w_full;

    atcb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    atcb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_queue_valid),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

    assign o_m_axis_tdata = {6'd0, w_res.bottom, w_res.right, w_res.top,
                             w_res.left, w_res.status};

endmodule
